[rtl/lsc_pkg.sv]
// ----------------------------------------------------------------------------
// lsc_pkg
// Types and constants shared by the LED matrix row scanner.
// ----------------------------------------------------------------------------
package lsc_pkg;

	localparam int ROW_IDX_W   = 3;
	localparam int BANK_SIZE   = 1 << ROW_IDX_W;
	localparam int ADDR_W      = ROW_IDX_W + 1;
	localparam int MEM_DEPTH   = 2 * BANK_SIZE;
	localparam int COL_W       = 8;
	localparam int ROW_CNT_W   = 4;
	localparam int MAX_ROWS_DEF = 8;

	localparam logic [COL_W-1:0] ALL_OFF = 8'hff;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_TICK  = 1'b1
	} lsc_op_t;

	typedef struct packed {
		lsc_op_t              operation;
		logic [ROW_IDX_W-1:0] row_index;
		logic [COL_W-1:0]     row_data;
		logic                 last_of_frame;
	} lsc_in_t;

	typedef struct packed {
		logic [COL_W-1:0] column_data;
		logic [COL_W-1:0] row_select;
	} lsc_out_t;

	// frame store access from the scan control
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [COL_W-1:0]  wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} lsc_mem_req_t;

endpackage

[rtl/led_matrix_row_scanner_unit.sv]
// A tick beat's result passes the read stage, then the output register.
// Throughput: one beat per cycle when not stalled; the store has one write and
// one read port and a beat uses one of them, so writes and ticks mix freely.
// Input stalls only while the read stage and output register are both full.
// Reset clears the flags, row counter and store valid bits (store reads zero).
// ----------------------------------------------------------------------------
// led_matrix_row_scanner_unit
// Double-buffered row multiplexer for a binary LED matrix.
// ----------------------------------------------------------------------------
module led_matrix_row_scanner_unit
	import lsc_pkg::*;
#(
	parameter int MAX_ROWS = MAX_ROWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  lsc_in_t              in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output lsc_out_t             out_item,
	input  logic                 cfg_we,
	input  logic [ROW_CNT_W-1:0] cfg_wdata
);

	lsc_mem_req_t     req;
	logic             fire;
	logic [COL_W-1:0] rsel;
	logic [COL_W-1:0] rdata;
	logic             hold;
	logic             accept;

	assign in_stall = hold;
	assign accept   = in_valid && !hold;

	lsc_scan_ctrl #(
		.MAX_ROWS(MAX_ROWS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (in_item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req),
		.fire     (fire),
		.rsel     (rsel)
	);

	lsc_frame_mem u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rdata (rdata)
	);

	lsc_out_buf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.rsel     (rsel),
		.rdata    (rdata),
		.hold     (hold),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

endmodule

[rtl/lsc_frame_mem.sv]
// ----------------------------------------------------------------------------
// lsc_frame_mem
// Two-bank frame store, one write and one registered read per cycle.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module lsc_frame_mem
	import lsc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  lsc_mem_req_t     req,
	output logic [COL_W-1:0] rdata
);

	logic [COL_W-1:0]     mem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] vld_q;
	logic [COL_W-1:0]     rdata_q;
	logic                 rhit_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rhit_q <= 1'b0;
		end else begin
			if (req.we) begin
				vld_q[req.waddr] <= 1'b1;
			end
			if (req.re) begin
				rhit_q <= vld_q[req.raddr];
			end
		end
	end

	assign rdata = rhit_q ? rdata_q : '0;

endmodule

[rtl/lsc_scan_ctrl.sv]
// ----------------------------------------------------------------------------
// lsc_scan_ctrl
// Bank select, row counter and frame flags; turns each beat into a
// frame store write or read.
// ----------------------------------------------------------------------------
module lsc_scan_ctrl
	import lsc_pkg::*;
#(
	parameter int MAX_ROWS = MAX_ROWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  lsc_in_t              item,
	input  logic                 cfg_we,
	input  logic [ROW_CNT_W-1:0] cfg_wdata,
	output lsc_mem_req_t         req,
	output logic                 fire,
	output logic [COL_W-1:0]     rsel
);

	localparam logic [ROW_CNT_W-1:0] MAX_ROWS_C = ROW_CNT_W'(MAX_ROWS);
	localparam logic [ROW_CNT_W-1:0] ONE_ROW    = ROW_CNT_W'(1);

	logic [ROW_CNT_W-1:0] row_count_q;
	logic                 front_q;
	logic [ROW_CNT_W-1:0] scan_row_q;
	logic                 pending_q;
	logic                 ready_q;

	logic [ROW_CNT_W-1:0] eff_rows;
	logic                 wrap;
	logic [ROW_IDX_W-1:0] row;
	logic                 front_nxt;
	logic                 is_wr;

	always_comb begin
		eff_rows = row_count_q;
		if (row_count_q == '0) begin
			eff_rows = ONE_ROW;
		end else if (row_count_q > MAX_ROWS_C) begin
			eff_rows = MAX_ROWS_C;
		end
	end

	assign is_wr     = accept && (item.operation == OP_WRITE);
	assign fire      = accept && (item.operation == OP_TICK) && ready_q;
	assign wrap      = scan_row_q >= eff_rows;
	assign row       = wrap ? '0 : scan_row_q[ROW_IDX_W-1:0];
	// a pending frame goes to the front as the scan wraps
	assign front_nxt = (wrap && pending_q) ? ~front_q : front_q;
	assign rsel      = ~(COL_W'(1) << row) & ALL_OFF;

	always_comb begin
		req.we    = is_wr;
		req.waddr = {~front_q, item.row_index};
		req.wdata = item.row_data;
		req.re    = fire;
		req.raddr = {front_nxt, row};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= MAX_ROWS_C;
			front_q     <= 1'b0;
			scan_row_q  <= '0;
			pending_q   <= 1'b0;
			ready_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				row_count_q <= cfg_wdata;
			end
			if (is_wr) begin
				pending_q <= item.last_of_frame;
				if (item.last_of_frame) begin
					ready_q <= 1'b1;
				end
			end else if (fire) begin
				front_q    <= front_nxt;
				scan_row_q <= ROW_CNT_W'(row) + ONE_ROW;
				if (wrap) begin
					pending_q <= 1'b0;
				end
			end
		end
	end

endmodule

[rtl/lsc_out_buf.sv]
// ----------------------------------------------------------------------------
// lsc_out_buf
// Read stage and output register; back-pressure reaches the input only
// when both hold a beat.
// ----------------------------------------------------------------------------
module lsc_out_buf
	import lsc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [COL_W-1:0] rsel,
	input  logic [COL_W-1:0] rdata,
	output logic             hold,
	output logic             out_valid,
	input  logic             out_stall,
	output lsc_out_t         out_item
);

	logic             valid_s1;
	logic [COL_W-1:0] rsel_s1;
	logic             out_valid_q;
	lsc_out_t         out_q;
	logic             move;

	assign move = valid_s1 && !(out_valid_q && out_stall);
	assign hold = valid_s1 && out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsel_s1 <= rsel;
		end
		if (move) begin
			out_q.column_data <= rdata;
			out_q.row_select  <= rsel_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

[rtl/lsc_checker.sv]
// ----------------------------------------------------------------------------
// lsc_checker
// Port-level checks on the row scanner, bound to the top level.
// ----------------------------------------------------------------------------
module lsc_checker
	import lsc_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input lsc_in_t              in_item,
	input logic                 out_valid,
	input logic                 out_stall,
	input lsc_out_t             out_item
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_item))
		else $error("stalled output beat changed");

	a_one_cold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones(out_item.row_select) == COL_W - 1)
		else $error("row select not one-cold");

	// a fresh result is always caused by an earlier accepted tick beat
	a_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |->
			$past(in_valid && !in_stall && in_item.operation == OP_TICK, 2))
		else $error("result without a tick beat");

endmodule

bind led_matrix_row_scanner_unit lsc_checker u_lsc_checker (.*);

[verif/led_matrix_row_scanner_unit_checker.sv]
// ----------------------------------------------------------------------------
// led_matrix_row_scanner_unit_checker
// Watches the beat channels and the row count port of the row scanner, keeps
// its own copy of both frame banks, flags and scan row, predicts the column
// byte and row select of every tick after the first frame; checks in order.
// ----------------------------------------------------------------------------
module led_matrix_row_scanner_unit_checker
	import lsc_pkg::*;
#(
	parameter int MAX_ROWS = MAX_ROWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  lsc_in_t              in_item,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  lsc_out_t             out_item,
	input  logic                 cfg_we,
	input  logic [ROW_CNT_W-1:0] cfg_wdata,
	output int                   fail_count,
	output int                   pending
);

	logic [COL_W-1:0]     frame_mem [MEM_DEPTH];
	logic                 front_bank;
	logic [ROW_CNT_W-1:0] scan_pos;
	logic [ROW_CNT_W-1:0] rows_cfg;
	logic                 frame_waiting;
	logic                 scan_armed;
	lsc_out_t             shown_q [$];
	int                   errs = 0;

	function automatic int shown_rows();
		int n;
		n = int'(rows_cfg);
		if (n < 1)
			n = 1;
		if (n > MAX_ROWS)
			n = MAX_ROWS;
		if (n > BANK_SIZE)
			n = BANK_SIZE;
		return n;
	endfunction

	task automatic note_miss(input string what, input logic [COL_W-1:0] want,
			input logic [COL_W-1:0] got);
		errs++;
		if (errs <= 10)
			$display("%0t: %s mismatch: expected %02h, got %02h", $time, what, want, got);
	endtask

	task automatic predict_beat(input lsc_in_t b);
		logic [ROW_IDX_W-1:0] row;
		lsc_out_t             res;
		if (b.operation == OP_WRITE) begin
			// writes always land in the bank not being shown
			frame_mem[{~front_bank, b.row_index}] = b.row_data;
			if (b.last_of_frame) begin
				frame_waiting = 1'b1;
				scan_armed    = 1'b1;
			end else begin
				frame_waiting = 1'b0;
			end
		end else if (scan_armed) begin
			// wrap also catches a row count lowered in mid scan
			if (int'(scan_pos) >= shown_rows()) begin
				scan_pos = '0;
				if (frame_waiting) begin
					front_bank    = ~front_bank;
					frame_waiting = 1'b0;
				end
			end
			row             = scan_pos[ROW_IDX_W-1:0];
			res.column_data = frame_mem[{front_bank, row}];
			res.row_select  = ALL_OFF & ~(COL_W'(1) << row);
			shown_q.push_back(res);
			scan_pos = scan_pos + ROW_CNT_W'(1);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		lsc_out_t want;
		if (!arst_n) begin
			for (int i = 0; i < MEM_DEPTH; i++)
				frame_mem[i] = '0;
			front_bank    = 1'b0;
			scan_pos      = '0;
			rows_cfg      = ROW_CNT_W'(MAX_ROWS);
			frame_waiting = 1'b0;
			scan_armed    = 1'b0;
			shown_q.delete();
			pending    <= 0;
			fail_count <= errs;
		end else begin
			// results first: a beat accepted at this edge cannot have its result yet
			if (out_valid && !out_stall) begin
				if (shown_q.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("%0t: unexpected beat: column %02h, row select %02h",
							$time, out_item.column_data, out_item.row_select);
				end else begin
					want = shown_q.pop_front();
					if (out_item.column_data !== want.column_data)
						note_miss("column_data", want.column_data, out_item.column_data);
					if (out_item.row_select !== want.row_select)
						note_miss("row_select", want.row_select, out_item.row_select);
				end
			end
			if (in_valid && !in_stall)
				predict_beat(in_item);
			if (cfg_we)
				rows_cfg = cfg_wdata;
			pending    <= shown_q.size();
			fail_count <= errs;
		end
	end

endmodule

[verif/led_matrix_row_scanner_unit_test.sv]
// ----------------------------------------------------------------------------
// led_matrix_row_scanner_unit_test
// Drives frame writes and scan ticks into the row scanner under several row
// counts, with random idling on both sides and one long output hold-off;
// the checker beside the block predicts and compares every shown row.
// ----------------------------------------------------------------------------
module led_matrix_row_scanner_unit_test;
	import lsc_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_AT        = 400;
	localparam int HOLD_CYCLES    = 120;
	localparam int PHASE_BEATS    = 165;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	lsc_in_t              in_item;
	logic                 out_valid;
	logic                 out_stall;
	lsc_out_t             out_item;
	logic                 cfg_we;
	logic [ROW_CNT_W-1:0] cfg_wdata;
	int                   fail_count;
	int                   pending;
	bit                   quiet = 1'b0;
	int                   beats_sent = 0;
	int                   dead_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	led_matrix_row_scanner_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	led_matrix_row_scanner_unit_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			dead_cycles <= 0;
		end else if (dead_cycles >= WATCHDOG_LIMIT) begin
			$display("** led_matrix_row_scanner_unit: FAILED **");
			$finish;
		end else begin
			dead_cycles <= dead_cycles + 1;
		end
	end

	// receiver: random stalls, plus one long hold-off so the block backs up
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && beats_sent >= HOLD_AT) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= !quiet && ($urandom_range(0, 99) < 33);
		end
	end

	function automatic logic [COL_W-1:0] rand_byte();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return ALL_OFF;
			default: return COL_W'($urandom);
		endcase
	endfunction

	function automatic lsc_in_t write_item(input int idx, input logic [COL_W-1:0] data,
			input bit last);
		lsc_in_t b;
		b.operation     = OP_WRITE;
		b.row_index     = ROW_IDX_W'(idx);
		b.row_data      = data;
		b.last_of_frame = last;
		return b;
	endfunction

	// unused fields of a tick carry noise
	function automatic lsc_in_t tick_item();
		lsc_in_t b;
		b.operation     = OP_TICK;
		b.row_index     = ROW_IDX_W'($urandom);
		b.row_data      = COL_W'($urandom);
		b.last_of_frame = 1'($urandom_range(0, 1));
		return b;
	endfunction

	task automatic send_beat(input lsc_in_t b);
		if (!quiet && $urandom_range(0, 99) < 33) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= b;
		do
			@(posedge clk);
		while (in_stall);
		beats_sent++;
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_beat(tick_item());
	endtask

	// drains the block first; writes give no result, so it also waits out
	// the pipeline after pending reaches zero
	task automatic set_rows(input logic [ROW_CNT_W-1:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic random_traffic(input int n);
		int start;
		int rows;
		start = beats_sent;
		while (beats_sent - start < n) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					// whole frame, rows in order, last flag on the final one
					rows = $urandom_range(1, BANK_SIZE);
					for (int r = 0; r < rows; r++)
						send_beat(write_item(r, rand_byte(), r == rows - 1));
					send_ticks($urandom_range(1, 12));
				end
				5, 6, 7:
					send_ticks($urandom_range(1, 20));
				8:
					send_beat(write_item($urandom_range(0, BANK_SIZE - 1), rand_byte(),
						1'($urandom_range(0, 1))));
				default: begin
					// completed frame spoilt by a later write
					send_beat(write_item($urandom_range(0, BANK_SIZE - 1), rand_byte(), 1'b1));
					send_beat(write_item($urandom_range(0, BANK_SIZE - 1), rand_byte(), 1'b0));
					send_ticks($urandom_range(1, 10));
				end
			endcase
		end
	endtask

	initial begin
		logic [ROW_CNT_W-1:0] rows_plan [6];
		rows_plan = '{4'd0, 4'd1, 4'd15, 4'd8, 4'd3, 4'd5};
		arst_n = 1'b0;
		in_valid  <= 1'b0;
		in_item   <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ticks before the first frame show nothing
		send_ticks(2);
		send_beat(write_item(0, 8'h00, 1'b0));
		send_beat(write_item(1, 8'hff, 1'b0));
		send_beat(write_item(2, 8'h55, 1'b0));
		send_beat(write_item(3, 8'haa, 1'b0));
		send_beat(write_item(4, 8'h01, 1'b0));
		send_beat(write_item(5, 8'h80, 1'b0));
		send_beat(write_item(6, 8'h3c, 1'b0));
		send_beat(write_item(7, 8'hff, 1'b1));
		// old bank for a full scan, then the swap at the wrap
		send_ticks(10);
		send_beat(write_item(2, 8'hc3, 1'b1));
		send_beat(write_item(5, 8'h00, 1'b0));
		send_ticks(3);

		foreach (rows_plan[p]) begin
			set_rows(p == 5 ? ROW_CNT_W'($urandom_range(2, 7)) : rows_plan[p]);
			quiet = (p == 3);
			random_traffic(PHASE_BEATS);
		end
		quiet = 1'b0;

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		if (fail_count == 0)
			$display("** led_matrix_row_scanner_unit: PASSED **");
		else
			$display("** led_matrix_row_scanner_unit: FAILED **");
		$finish;
	end

endmodule

[filelist.f]
rtl/lsc_pkg.sv
rtl/lsc_frame_mem.sv
rtl/lsc_scan_ctrl.sv
rtl/lsc_out_buf.sv
rtl/led_matrix_row_scanner_unit.sv
rtl/lsc_checker.sv
verif/led_matrix_row_scanner_unit_checker.sv
verif/led_matrix_row_scanner_unit_test.sv
